// ----- rtl/core/frequent_items_summary_defines.svh -----
// ----------------------------------------------------------------------------
// Frequent items summary: assertion macros
// Shared forms for the concurrent checks of the summary block.
// ----------------------------------------------------------------------------
`ifndef FREQUENT_ITEMS_SUMMARY_DEFINES_SVH
`define FREQUENT_ITEMS_SUMMARY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequent items summary package
// Widths, codes and cell control types shared by the summary modules.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int CAP_W      = 5;
    localparam int KIND_W     = 2;
    localparam int OUTCOME_W  = 2;
    localparam int M_TDATA_W  = 72;
    localparam int M_PAD_W    = M_TDATA_W - OUTCOME_W - DATA_W - COUNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUTCOME_COUNTED     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DECREMENTED = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NONE        = 2'd0;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INC,
        CELL_INS,
        CELL_DEC,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;
        logic live;
    } cell_stat_t;

endpackage

// ----- rtl/core/fis_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Summary cell
// One slot of the table: a key and a saturating count, compared against the
// broadcast key and rotated towards the head of the row during a report.
// ----------------------------------------------------------------------------
module fis_cell import fis_pkg::*; #(
    parameter int KEY_W = DEF_KEY_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic               sel,
    input  logic [KEY_W-1:0]   value,
    input  logic [KEY_W-1:0]   next_key,
    input  logic [COUNT_W-1:0] next_count,
    output logic [KEY_W-1:0]   key,
    output logic [COUNT_W-1:0] count,
    output cell_stat_t         stat
);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb begin
        key_next   = key_reg;
        count_next = count_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INC: begin
                if (sel && count_reg != '1) begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CELL_INS: begin
                if (sel) begin
                    key_next   = value;
                    count_next = COUNT_W'(1);
                end
            end
            CELL_DEC: begin
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            CELL_ROT: begin
                key_next   = next_key;
                count_next = next_count;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key       = key_reg;
    assign count     = count_reg;
    assign stat.live = (count_reg != '0);
    assign stat.hit  = (count_reg != '0) && (key_reg == value);

endmodule

// ----- rtl/core/fis_live_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Live slot counter
// Two-stage registered adder tree that counts the occupied cells.
// ----------------------------------------------------------------------------
module fis_live_count import fis_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [MAX_ENTRIES-1:0] live,
    output logic [CNT_W-1:0]       cnt
);

    localparam int GROUPS = (MAX_ENTRIES + 7) / 8;
    localparam int PAD_W  = GROUPS * 8;

    logic [PAD_W-1:0] live_pad;
    logic [3:0]       grp_next [GROUPS];
    logic [3:0]       grp_reg  [GROUPS];
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_reg;

    assign live_pad = PAD_W'(live);

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = '0;
            for (int b = 0; b < 8; b++) begin
                grp_next[g] = grp_next[g] + 4'(live_pad[g*8 + b]);
            end
        end
    end

    always_comb begin
        cnt_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            cnt_next = cnt_next + CNT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUPS; g++) begin
                grp_reg[g] <= '0;
            end
            cnt_reg <= '0;
        end else begin
            grp_reg <= grp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

// ----- rtl/core/frequent_items_summary.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequent items summary
// Misra-Gries heavy-hitter table built as a ring of key and count cells.
// ----------------------------------------------------------------------------
// An add item is accepted in the idle state, then in the add state every cell
// compares its key in parallel and the whole row is updated. After an insert
// or a decrement the occupied-slot count comes from a two-stage adder tree,
// so the following add waits for that count to settle. A report rotates the
// ring of cells once round, one cell per cycle unless a live cell waits for
// the output; a report of an empty table gives a single empty result.
// The table is empty after reset with no start-up pass.
`include "frequent_items_summary_defines.svh"

module frequent_items_summary import fis_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_W-1:0]     cfg_data,    // capacity_limit
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,     // value
    input  logic                 s_tuser,     // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // outcome, key, count, zero pad
    output logic [KIND_W-1:0]    m_tuser,     // kind
    output logic                 m_tlast
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CUR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(MAX_ENTRIES - 1);
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_REPORT,
        ST_EMPTY
    } state_t;

    state_t                 state_reg, state_next;
    logic [KEY_WIDTH-1:0]   value_reg, value_next;
    logic [MAX_ENTRIES-1:0] rem_reg, rem_next;
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic [1:0]             settle_reg, settle_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [OUTCOME_W-1:0]   outcome_reg, outcome_next;
    logic [DATA_W-1:0]      key_reg, key_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic [KEY_WIDTH-1:0]   in_key;
    logic [DATA_W-1:0]      head_key;
    logic [KEY_WIDTH-1:0]   cell_key   [MAX_ENTRIES];
    logic [COUNT_W-1:0]     cell_count [MAX_ENTRIES];
    cell_stat_t             cell_stat  [MAX_ENTRIES];
    cell_ctrl_t             cell_ctrl;
    logic [MAX_ENTRIES-1:0] sel_vec;
    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] live_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] free_first;
    logic [CNT_W-1:0]       live_cnt;
    logic                   out_free;
    logic                   ins_ok;

    generate
        if (KEY_WIDTH <= DATA_W) begin : g_in_narrow
            assign in_key = s_tdata[KEY_WIDTH-1:0];
        end else begin : g_in_wide
            assign in_key = {{(KEY_WIDTH - DATA_W){1'b0}}, s_tdata};
        end
        if (KEY_WIDTH >= DATA_W) begin : g_out_narrow
            assign head_key = cell_key[0][DATA_W-1:0];
        end else begin : g_out_wide
            assign head_key = {{(DATA_W - KEY_WIDTH){1'b0}}, cell_key[0]};
        end
    endgenerate

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        fis_cell #(
            .KEY_W(KEY_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .sel       (sel_vec[i]),
            .value     (value_reg),
            .next_key  (cell_key[(i + 1) % MAX_ENTRIES]),
            .next_count(cell_count[(i + 1) % MAX_ENTRIES]),
            .key       (cell_key[i]),
            .count     (cell_count[i]),
            .stat      (cell_stat[i])
        );
        assign hit_vec[i]  = cell_stat[i].hit;
        assign live_vec[i] = cell_stat[i].live;
    end

    fis_live_count #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_live_count (
        .aclk   (aclk),
        .aresetn(aresetn),
        .live   (live_vec),
        .cnt    (live_cnt)
    );

    assign free_vec   = ~live_vec;
    assign free_first = free_vec & (~free_vec + MAX_ENTRIES'(1));
    assign ins_ok     = (CMP_W'(live_cnt) < CMP_W'(cap_reg)) && (free_vec != '0);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        value_next    = value_reg;
        rem_next      = rem_reg;
        cursor_next   = cursor_reg;
        settle_next   = (settle_reg != '0) ? settle_reg - 2'd1 : settle_reg;
        cap_next      = cfg_valid ? cfg_data : cap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        kind_next     = kind_reg;
        outcome_next  = outcome_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        cell_ctrl.op  = CELL_HOLD;
        sel_vec       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_ADD) begin
                        value_next = in_key;
                        state_next = ST_ADD;
                    end else if (live_vec == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        rem_next    = live_vec;
                        cursor_next = '0;
                        state_next  = ST_REPORT;
                    end
                end
            end
            ST_ADD: begin
                if (settle_reg == '0 && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    kind_next     = KIND_ACK;
                    key_next      = '0;
                    count_next    = '0;
                    if (hit_vec != '0) begin
                        cell_ctrl.op = CELL_INC;
                        sel_vec      = hit_vec;
                        outcome_next = OUTCOME_COUNTED;
                    end else if (ins_ok) begin
                        cell_ctrl.op = CELL_INS;
                        sel_vec      = free_first;
                        settle_next  = SETTLE_CYCLES;
                        outcome_next = OUTCOME_INSERTED;
                    end else begin
                        cell_ctrl.op = CELL_DEC;
                        settle_next  = SETTLE_CYCLES;
                        outcome_next = OUTCOME_DECREMENTED;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    kind_next     = KIND_EMPTY;
                    outcome_next  = OUTCOME_NONE;
                    key_next      = '0;
                    count_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (!rem_reg[0] || out_free) begin
                    cell_ctrl.op = CELL_ROT;
                    if (rem_reg[0]) begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = ((rem_reg >> 1) == '0);
                        kind_next     = KIND_ENTRY;
                        outcome_next  = OUTCOME_NONE;
                        key_next      = head_key;
                        count_next    = cell_count[0];
                    end
                    rem_next    = rem_reg >> 1;
                    cursor_next = cursor_reg + CUR_W'(1);
                    if (cursor_reg == CUR_LAST) begin
                        cursor_next = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rem_reg      <= '0;
            cursor_reg   <= '0;
            settle_reg   <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rem_reg      <= rem_next;
            cursor_reg   <= cursor_next;
            settle_reg   <= settle_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        value_reg   <= value_next;
        m_tlast_reg <= m_tlast_next;
        kind_reg    <= kind_next;
        outcome_reg <= outcome_next;
        key_reg     <= key_next;
        count_reg   <= count_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = kind_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, count_reg, key_reg, outcome_reg};

    `FIS_ASSERT_IMPLIES(a_single_hit, aclk, aresetn, 1'b1, $onehot0(hit_vec), "key held twice")
    `FIS_ASSERT_IMPLIES(a_live_count, aclk, aresetn, settle_reg == '0, int'(live_cnt) == $countones(live_vec), "live count stale")
    `FIS_ASSERT_IMPLIES(a_insert_room, aclk, aresetn, cell_ctrl.op == CELL_INS, int'(live_cnt) < int'(cap_reg), "insert beyond capacity")
    `FIS_ASSERT_NEXT(a_report_keeps, aclk, aresetn, state_reg == ST_REPORT, $countones(live_vec) == $past($countones(live_vec)), "report changed the table")

endmodule

// ----- sim/tb_frequent_items_summary.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequent items summary testbench
// Drives add and report items into the heavy-hitter table and predicts every
// result in a model of its own. A short directed table comes first, then
// random phases at several capacity settings, with idling on both sides and
// one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_frequent_items_summary import fis_pkg::*; ();

    localparam int MAX_ENTRIES     = DEF_MAX_ENTRIES;
    localparam int SETTLE_CYCLES   = MAX_ENTRIES + 8;
    localparam int HOLD_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int NUM_ROWS        = 27;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [OUTCOME_W-1:0] outcome;
        logic [DATA_W-1:0]    key;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } summary_result_t;

    typedef enum logic [1:0] {
        ROW_ADD,
        ROW_REPORT,
        ROW_SETCAP
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [DATA_W-1:0]    value;
        bit                   typed;
        logic [KIND_W-1:0]    res_kind;
        logic [OUTCOME_W-1:0] res_outcome;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    logic [DATA_W-1:0]  table_key [MAX_ENTRIES];
    logic [COUNT_W-1:0] table_count [MAX_ENTRIES];
    logic [CAP_W-1:0]   capacity;

    summary_result_t pending_results [$];
    summary_result_t got_result;
    summary_result_t want_result;
    int              mismatch_count = 0;
    int              cycle_count = 0;
    bit              calm;
    bit              hold_request;
    bit              hold_done;

    logic [CAP_W-1:0]  phase_caps [NUM_PHASES] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd9};
    logic [DATA_W-1:0] key_pool [MAX_ENTRIES + 4];

    directed_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_REPORT, 32'h0,        1'b1, KIND_EMPTY, OUTCOME_NONE},
        '{ROW_ADD,    32'h0,        1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_ADD,    32'hFFFFFFFF, 1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_ADD,    32'h0,        1'b1, KIND_ACK,   OUTCOME_COUNTED},
        '{ROW_ADD,    32'hA5A5A5A5, 1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_REPORT, 32'hFFFFFFFF, 1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_SETCAP, 32'd2,        1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_ADD,    32'h0,        1'b1, KIND_ACK,   OUTCOME_COUNTED},
        '{ROW_ADD,    32'h12345678, 1'b1, KIND_ACK,   OUTCOME_DECREMENTED},
        '{ROW_ADD,    32'h12345678, 1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_ADD,    32'h5A5A5A5A, 1'b1, KIND_ACK,   OUTCOME_DECREMENTED},
        '{ROW_REPORT, 32'h0,        1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_SETCAP, 32'd0,        1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_ADD,    32'h0,        1'b1, KIND_ACK,   OUTCOME_COUNTED},
        '{ROW_ADD,    32'h77,       1'b1, KIND_ACK,   OUTCOME_DECREMENTED},
        '{ROW_ADD,    32'h77,       1'b1, KIND_ACK,   OUTCOME_DECREMENTED},
        '{ROW_ADD,    32'h77,       1'b1, KIND_ACK,   OUTCOME_DECREMENTED},
        '{ROW_REPORT, 32'h0,        1'b1, KIND_EMPTY, OUTCOME_NONE},
        '{ROW_SETCAP, 32'd31,       1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_ADD,    32'h80000000, 1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_ADD,    32'h7FFFFFFF, 1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_REPORT, 32'h0,        1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_SETCAP, 32'd1,        1'b0, KIND_ACK,   OUTCOME_NONE},
        '{ROW_ADD,    32'h1,        1'b1, KIND_ACK,   OUTCOME_DECREMENTED},
        '{ROW_ADD,    32'h1,        1'b1, KIND_ACK,   OUTCOME_INSERTED},
        '{ROW_ADD,    32'h1,        1'b1, KIND_ACK,   OUTCOME_COUNTED},
        '{ROW_REPORT, 32'h0,        1'b0, KIND_ACK,   OUTCOME_NONE}
    };

    frequent_items_summary dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
        return (cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap);
    endfunction

    function automatic void predict_summary(input logic op, input logic [DATA_W-1:0] value,
                                            output summary_result_t res [$]);
        int live;
        int hit;
        int free_slot;
        int last_live;
        res = {};
        if (op == OP_ADD) begin
            live = 0;
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (table_count[i] != 0) begin
                    live++;
                    if (hit < 0 && table_key[i] == value) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                if (table_count[hit] != '1) table_count[hit]++;
                res.push_back('{KIND_ACK, OUTCOME_COUNTED, '0, '0, 1'b1});
            end else if (live < effective_capacity(capacity) && free_slot >= 0) begin
                table_key[free_slot] = value;
                table_count[free_slot] = 1;
                res.push_back('{KIND_ACK, OUTCOME_INSERTED, '0, '0, 1'b1});
            end else begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (table_count[i] != 0) table_count[i]--;
                res.push_back('{KIND_ACK, OUTCOME_DECREMENTED, '0, '0, 1'b1});
            end
        end else begin
            last_live = -1;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (table_count[i] != 0) last_live = i;
            if (last_live < 0) begin
                res.push_back('{KIND_EMPTY, OUTCOME_NONE, '0, '0, 1'b1});
            end else begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (table_count[i] != 0)
                        res.push_back('{KIND_ENTRY, OUTCOME_NONE, table_key[i],
                                        table_count[i], i == last_live});
            end
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input logic op, input logic [DATA_W-1:0] value, input bit typed,
                             input logic [KIND_W-1:0] res_kind,
                             input logic [OUTCOME_W-1:0] res_outcome);
        summary_result_t res [$];
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = value;
        do @(posedge aclk); while (!s_tready);
        predict_summary(op, value, res);
        if (typed)
            pending_results.push_back('{res_kind, res_outcome, '0, '0, 1'b1});
        else
            foreach (res[i]) pending_results.push_back(res[i]);
    endtask

    // The ring may still be rotating after the last entry of a report has left.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data = cap;
        do @(posedge aclk); while (!cfg_ready);
        capacity = cap;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_tready = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.kind    = m_tuser;
            got_result.outcome = m_tdata[OUTCOME_W-1:0];
            got_result.key     = m_tdata[OUTCOME_W +: DATA_W];
            got_result.count   = m_tdata[OUTCOME_W + DATA_W +: COUNT_W];
            got_result.last    = m_tlast;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending, kind", got_result.kind, '0);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.kind !== want_result.kind)
                    flag_mismatch("kind", got_result.kind, want_result.kind);
                if (got_result.outcome !== want_result.outcome)
                    flag_mismatch("outcome", got_result.outcome, want_result.outcome);
                if (got_result.key !== want_result.key)
                    flag_mismatch("key", got_result.key, want_result.key);
                if (got_result.count !== want_result.count)
                    flag_mismatch("count", got_result.count, want_result.count);
                if (got_result.last !== want_result.last)
                    flag_mismatch("last", got_result.last, want_result.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int n_keys;
        int pick;
        logic [DATA_W-1:0] value;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        calm = 1'b0;
        hold_request = 1'b0;
        capacity = CAP_RESET;
        foreach (table_count[i]) begin
            table_key[i] = '0;
            table_count[i] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_SETCAP: write_capacity(directed_rows[r].value[CAP_W-1:0]);
                ROW_REPORT: send_item(OP_REPORT, directed_rows[r].value, directed_rows[r].typed,
                                      directed_rows[r].res_kind, directed_rows[r].res_outcome);
                default: send_item(OP_ADD, directed_rows[r].value, directed_rows[r].typed,
                                   directed_rows[r].res_kind, directed_rows[r].res_outcome);
            endcase
        end

        // Each phase draws most keys from a small pool, skewed towards its
        // first members, so that matches, inserts and decrements all occur.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_caps[p]);
            if (p == 0) hold_request = 1'b1;
            if (p == NUM_PHASES - 1) calm = 1'b1;
            n_keys = effective_capacity(phase_caps[p]) + $urandom_range(1, 4);
            for (int k = 0; k < n_keys; k++) key_pool[k] = $urandom;
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    send_item(OP_REPORT, $urandom, 1'b0, KIND_ACK, OUTCOME_NONE);
                end else begin
                    if (pick < 24)
                        value = $urandom;
                    else
                        value = key_pool[$urandom_range(0, $urandom_range(0, n_keys - 1))];
                    send_item(OP_ADD, value, 1'b0, KIND_ACK, OUTCOME_NONE);
                end
            end
        end

        wait_idle();
        foreach (pending_results[i])
            flag_mismatch("result never arrived, kind", '0, pending_results[i].kind);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
